// ===== hdl/tlum_pkg.sv =====
// Shared constants and types for the tank level and usage monitor.
package tlum_pkg;

  localparam int SAMPLES_PER_BURST_DEF = 10;

  // Shared divider operand width
  localparam int DIV_W = 40;

  localparam logic [11:0] EMPTY_MV_RST    = 12'd1650;
  localparam logic [11:0] FULL_MV_RST     = 12'd2900;
  localparam logic [31:0] INTERVAL_MS_RST = 32'd3600000;
  localparam logic [6:0]  CUTOFF_RST      = 7'd5;

  // Register index (paddr[3:2])
  localparam logic [1:0] REG_EMPTY    = 2'd0;
  localparam logic [1:0] REG_FULL     = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_CUTOFF   = 2'd3;

  localparam logic [6:0]  LEVEL_MAX = 7'd100;
  localparam logic [19:0] DAYS_MAX  = 20'hFFFFF;

  typedef logic [DIV_W-1:0] div_word_t;

endpackage

// ===== hdl/tlum_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module tlum_div import tlum_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  div_word_t dividend,
  input  div_word_t divisor,
  output logic      busy,
  output logic      done,
  output div_word_t quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DIV_W:0]   trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        cnt      <= CW'(DIV_W);
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= DIV_W'(trial - {1'b0, dvs});
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= trial[DIV_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without running");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider still busy at done");

endmodule

// ===== hdl/tank_level_usage_monitor.sv =====
// Top level: burst averaging, level mapping, usage tracking and days estimate.
//
// Input beats carry one converter sample and its millisecond time. Zero samples
// are skipped. Every SAMPLES_PER_BURST-th beat closes a burst and yields one
// output beat. Other beats yield none and leave the block idle for the next one.
// A burst end runs a sequencer over one shared 40-bit restoring divider.
// Each division takes 40 iterations. The divisions are the average, the level
// and the days estimate.
// Millivolt rounding and usage smoothing use constant reciprocal multiplies.
// After the accepting edge of the burst's last sample, s_tready stays low while
// the sequence runs; the next sample is taken once the final step has loaded
// the output register and returned to idle.
// The result sits in an output register. If the receiver stalls, the block
// holds in its final step until the register frees, then accepts the next sample.
// Configuration goes through the APB port (four registers at 0x0, 0x4, 0x8,
// 0xC); the user must write them only while idle, unchecked by the block. Reset
// restores register defaults, empties the burst, clears the usage history and
// marks the level tracker uninitialized; no output beat is pending after reset.
module tank_level_usage_monitor import tlum_pkg::*; #(
  parameter int SAMPLES_PER_BURST = SAMPLES_PER_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // adc_sample[11:0], now_ms[43:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // level_percent[6:0], sensor_millivolts[18:7],
                                 // usage_rate_q8[33:19], days_remaining_q8[53:34]
  output logic        m_tuser,   // burst_invalid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;

  // floor(x / 4095) = (x * MV_RECIP) >> 36 for x below 2^24
  localparam logic [24:0] MV_RECIP  = 25'd16781314;
  // floor(x / 10) = (x * USE_RECIP) >> 24 for x below 2^20
  localparam logic [20:0] USE_RECIP = 21'd1677722;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_AVG   = 12'b000000000010,
    ST_MUL1  = 12'b000000000100,
    ST_MUL2  = 12'b000000001000,
    ST_MV    = 12'b000000010000,
    ST_SIGN  = 12'b000000100000,
    ST_LVL   = 12'b000001000000,
    ST_TRACK = 12'b000010000000,
    ST_USE   = 12'b000100000000,
    ST_DPREP = 12'b001000000000,
    ST_DAYS  = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  logic [11:0] empty_mv, full_mv;
  logic [31:0] interval_ms;
  logic [6:0]  cutoff;

  logic [PW-1:0] burst_pos;
  logic [15:0]   valid_sum, sum_next;
  logic [3:0]    valid_tally, tally_next;
  logic [31:0]   now_hold, last_check;
  logic [11:0]   avg, held_mv;
  logic [23:0]   prod_v, prod_e;
  logic [23:0]   mv_num;
  logic [19:0]   use_num;
  logic signed [33:0] num;
  logic signed [25:0] den;
  logic signed [33:0] num_abs;
  logic signed [25:0] den_abs;
  logic [6:0]    level, prev_level;
  logic          prev_valid, invalid;
  logic [15:0]   usage;
  logic [19:0]   days;
  logic signed [7:0] drop;

  logic      div_start, div_busy, div_done;
  div_word_t div_a, div_b, div_q;

  wire [11:0] sample  = s_tdata[11:0];
  wire [31:0] now_in  = s_tdata[43:12];
  wire        accept  = s_tvalid && s_tready;
  wire        cfg_wr  = psel && penable && pwrite && pready;

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;

  always_comb begin
    sum_next   = valid_sum;
    tally_next = valid_tally;
    if (sample != 12'd0) begin
      sum_next   = valid_sum + 16'(sample);
      tally_next = valid_tally + 4'd1;
    end
    num_abs = (den < 0) ? -num : num;
    den_abs = (den < 0) ? -den : den;
    drop    = $signed({1'b0, prev_level}) - $signed({1'b0, level});
  end

  always_comb begin
    case (paddr[3:2])
      REG_EMPTY:    prdata = {20'd0, empty_mv};
      REG_FULL:     prdata = {20'd0, full_mv};
      REG_INTERVAL: prdata = interval_ms;
      REG_CUTOFF:   prdata = {25'd0, cutoff};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_mv    <= EMPTY_MV_RST;
      full_mv     <= FULL_MV_RST;
      interval_ms <= INTERVAL_MS_RST;
      cutoff      <= CUTOFF_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_EMPTY:    empty_mv    <= pwdata[11:0];
        REG_FULL:     full_mv     <= pwdata[11:0];
        REG_INTERVAL: interval_ms <= pwdata;
        REG_CUTOFF:   cutoff      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      burst_pos   <= '0;
      valid_sum   <= '0;
      valid_tally <= '0;
      held_mv     <= '0;
      prev_valid  <= 1'b0;
      prev_level  <= '0;
      last_check  <= '0;
      usage       <= '0;
      div_start   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (accept) begin
          if (burst_pos == PW'(SAMPLES_PER_BURST - 1)) begin
            burst_pos   <= '0;
            valid_sum   <= '0;
            valid_tally <= '0;
            now_hold    <= now_in;
            if (tally_next == 4'd0) begin
              invalid <= 1'b1;
              level   <= '0;
              state   <= ST_TRACK;
            end else begin
              invalid   <= 1'b0;
              div_a     <= DIV_W'(sum_next);
              div_b     <= DIV_W'(tally_next);
              div_start <= 1'b1;
              state     <= ST_AVG;
            end
          end else begin
            burst_pos   <= burst_pos + 1'b1;
            valid_sum   <= sum_next;
            valid_tally <= tally_next;
          end
        end
        ST_AVG: begin
          div_start <= 1'b0;
          if (div_done) begin
            avg   <= div_q[11:0];
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_v <= 24'(avg) * 24'd3300;
          prod_e <= 24'(empty_mv) * 24'd4095;
          state  <= ST_MUL2;
        end
        ST_MUL2: begin
          num <= 34'(($signed({2'b0, prod_v}) - $signed({2'b0, prod_e})) * 34'sd100);
          den <= 26'(($signed({1'b0, full_mv}) - $signed({1'b0, empty_mv})) * 26'sd4095);
          // round half up: (v + 2047) / 4095
          mv_num <= prod_v + 24'd2047;
          state  <= ST_MV;
        end
        ST_MV: begin
          held_mv <= 12'((48'(mv_num) * 48'(MV_RECIP)) >> 36);
          state   <= ST_SIGN;
        end
        ST_SIGN: begin
          if (den == 26'sd0) begin
            level <= (prod_v >= prod_e) ? LEVEL_MAX : 7'd0;
            state <= ST_TRACK;
          end else if (num_abs <= 34'sd0) begin
            level <= '0;
            state <= ST_TRACK;
          end else begin
            div_a     <= DIV_W'(num_abs);
            div_b     <= DIV_W'(den_abs);
            div_start <= 1'b1;
            state     <= ST_LVL;
          end
        end
        ST_LVL: begin
          div_start <= 1'b0;
          if (div_done) begin
            level <= (div_q >= DIV_W'(100)) ? LEVEL_MAX : div_q[6:0];
            state <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          if (!prev_valid) begin
            if (level != 7'd0) begin
              prev_valid <= 1'b1;
              prev_level <= level;
              last_check <= now_hold;
            end
            state <= ST_DPREP;
          end else if ((now_hold - last_check) >= interval_ms) begin
            prev_level <= level;
            last_check <= now_hold;
            if (drop > 8'sd0 && usage != 16'd0) begin
              use_num <= 20'(usage) * 20'd7 + 20'(drop[6:0]) * 20'd768 + 20'd5;
              state   <= ST_USE;
            end else begin
              if (drop > 8'sd0) usage <= {drop[7:0], 8'd0};
              state <= ST_DPREP;
            end
          end else begin
            state <= ST_DPREP;
          end
        end
        ST_USE: begin
          usage <= 16'((44'(use_num) * 44'(USE_RECIP)) >> 24);
          state <= ST_DPREP;
        end
        ST_DPREP: begin
          if (level < cutoff || usage == 16'd0) begin
            days  <= '0;
            state <= ST_OUT;
          end else begin
            div_a     <= DIV_W'({level, 16'd0});
            div_b     <= DIV_W'({usage, 4'd0}) + DIV_W'({usage, 3'd0});
            div_start <= 1'b1;
            state     <= ST_DAYS;
          end
        end
        ST_DAYS: begin
          div_start <= 1'b0;
          if (div_done) begin
            days  <= (div_q > DIV_W'(DAYS_MAX)) ? DAYS_MAX : div_q[19:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {2'b0, days, usage[14:0], held_mv, level};
          m_tuser  <= invalid;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  tlum_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_AVG || state == ST_LVL || state == ST_DAYS))
    else $error("divider finished outside a wait step");
  a_busy_not_idle: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !s_tready)
    else $error("input taken while divider runs");
  a_out_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("output beat not from final step");

endmodule
